// File: hw/rtl/fsns_pkg.sv
`default_nettype none
package fsns_pkg;

  // 8.3 name geometry
  localparam int NAME_LEN   = 11;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 12;
  localparam int NAME_BITS  = 8 * NAME_LEN;
  localparam logic [POS_W-1:0] DOT_POS = POS_W'(8);
  localparam logic [POS_W-1:0] FULL_POS = POS_W'(NAME_LEN);

  // character and attribute constants
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7a;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] CH_DELETED = 8'he5;
  localparam logic [7:0] ATTR_SKIP  = 8'h18;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(224);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  // classified beat as it travels through the queue
  typedef struct packed {
    logic                 is_entry;
    logic                 first_char;
    logic [7:0]           name_byte;   // already upper case
    logic                 name_zero;
    logic                 name_dot;
    logic [NAME_BITS-1:0] entry_name;  // byte 0 in bits 7:0
    logic                 entry_end;
    logic                 entry_skip;
  } item_t;

  // queue head handshake toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage
`default_nettype wire

// File: hw/rtl/fsns_in_if.sv
`default_nettype none
interface fsns_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        first_char;
  logic [7:0]  name_char;
  logic [63:0] entry_name_low;
  logic [23:0] entry_name_high;
  logic [7:0]  entry_attr;

  modport source (
    output valid, req_type, first_char, name_char,
           entry_name_low, entry_name_high, entry_attr,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_char, name_char,
           entry_name_low, entry_name_high, entry_attr,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/fsns_out_if.sv
`default_nettype none
interface fsns_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] entry_index;

  modport source (output valid, status, entry_index, input ready);
  modport sink (input valid, status, entry_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fat_short_name_directory_search_top.sv
// FAT 8.3 short-name directory search.
// in_ch (valid/ready) carries one beat per name byte (req_type 0) or per
// directory entry (req_type 1). A name byte with first_char set starts a new
// name: pattern, too-long flag and entry count are cleared. Entries that
// follow are compared against the 8.3 pattern with one 11-byte compare.
// out_ch carries at most one result per search: found with the entry index,
// not found (end marker or entry limit), or name too long. Later entries are
// swallowed until the next first_char.
// cfg_wr_en/cfg_wr_data set max_entries (reset 224); write only when idle.
// Throughput: one beat per cycle while out_ch is not stalled. A result
// passes from its accepted entry beat through the two-entry queue and
// then the result register, where it is held until out_ch takes it.
// Reset clears the queue, the result register and the search state; the
// block is ready once reset has cleared the queue.
// When out_ch stalls, the back end holds its result and stops; the front keeps
// accepting until the queue is full, then drops ready.
`default_nettype none
module fat_short_name_directory_search_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  fsns_in_if.sink          in_ch,
  fsns_out_if.source       out_ch
);

  fsns_pkg::item_t                  push_item;
  logic                             push;
  logic                             full;
  logic                             pop;
  fsns_pkg::head_t                  head;
  logic [fsns_pkg::QCNT_W-1:0]      q_count;

  fsns_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .item  (push_item),
    .push  (push)
  );

  fsns_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .head      (head),
    .pop       (pop),
    .count     (q_count)
  );

  fsns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= fsns_pkg::QCNT_W'(fsns_pkg::QUEUE_DEPTH))
    else $error("queue overfilled");

  // no pop while the result register is blocked
  a_pop_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !pop)
    else $error("pop while result stalled");

  // index only reported with a found status
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != fsns_pkg::ST_FOUND) |-> (out_ch.entry_index == 12'd0))
    else $error("index on non-found result");

  // status stays within its codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.status == fsns_pkg::ST_FOUND ||
                      out_ch.status == fsns_pkg::ST_NOT_FOUND ||
                      out_ch.status == fsns_pkg::ST_TOO_LONG))
    else $error("bad status code");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/fsns_front.sv
`default_nettype none
module fsns_front (
  fsns_in_if.sink          in_ch,
  input  wire logic        full,
  output fsns_pkg::item_t  item,
  output logic             push
);

  logic [7:0] c;

  assign c = in_ch.name_char;

  // accept whenever the queue has room
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // classify the beat
  always_comb begin
    item.is_entry   = in_ch.req_type;
    item.first_char = in_ch.first_char && !in_ch.req_type;
    if (c >= fsns_pkg::CH_LOW_A && c <= fsns_pkg::CH_LOW_Z) begin
      item.name_byte = c & ~fsns_pkg::CASE_BIT;
    end else begin
      item.name_byte = c;
    end
    item.name_zero  = (c == fsns_pkg::CH_NUL);
    item.name_dot   = (c == fsns_pkg::CH_DOT);
    item.entry_name = {in_ch.entry_name_high, in_ch.entry_name_low};
    item.entry_end  = (in_ch.entry_name_low[7:0] == fsns_pkg::CH_NUL);
    item.entry_skip = (in_ch.entry_name_low[7:0] == fsns_pkg::CH_DELETED) ||
                      ((in_ch.entry_attr & fsns_pkg::ATTR_SKIP) != 8'h00);
  end

endmodule
`default_nettype wire

// File: hw/rtl/fsns_queue.sv
`default_nettype none
module fsns_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire fsns_pkg::item_t               push_item,
  output logic                               full,
  output fsns_pkg::head_t                    head,
  input  wire logic                          pop,
  output logic [fsns_pkg::QCNT_W-1:0]        count
);

  fsns_pkg::item_t                 mem [fsns_pkg::QUEUE_DEPTH];
  logic [fsns_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fsns_pkg::QPTR_W-1:0]     rd_ptr;
  logic                            do_pop;

  assign full       = (count == fsns_pkg::QCNT_W'(fsns_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fsns_pkg::QPTR_W'(fsns_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == fsns_pkg::QPTR_W'(fsns_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/fsns_back.sv
`default_nettype none
module fsns_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [fsns_pkg::CNT_W-1:0]   cfg_wr_data,
  input  wire fsns_pkg::head_t              head,
  output logic                              pop,
  fsns_out_if.source                        out_ch
);

  logic [7:0]                      pattern      [fsns_pkg::NAME_LEN];
  logic [7:0]                      pattern_next [fsns_pkg::NAME_LEN];
  logic [fsns_pkg::POS_W-1:0]      fill_pos, fill_pos_next;
  logic                            too_long, too_long_next;
  logic [fsns_pkg::CNT_W-1:0]      entry_count, entry_count_next;
  logic                            decided, decided_next;
  logic [fsns_pkg::CNT_W-1:0]      max_entries;
  logic [fsns_pkg::NAME_BITS-1:0]  pattern_flat;
  logic [fsns_pkg::CNT_W-1:0]      count_inc;
  logic                            advance;
  logic                            emit;
  fsns_pkg::status_t               emit_status;
  logic [fsns_pkg::CNT_W-1:0]      emit_index;
  logic                            out_valid;
  fsns_pkg::status_t               out_status;
  logic [fsns_pkg::CNT_W-1:0]      out_index;
  fsns_pkg::item_t                 it;

  assign it      = head.item;
  assign advance = !out_valid || out_ch.ready;
  assign pop     = head.valid && advance;

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.entry_index = out_index;

  assign count_inc = entry_count + 1'b1;

  // pattern laid out like an entry name
  always_comb begin
    for (int i = 0; i < fsns_pkg::NAME_LEN; i++) begin
      pattern_flat[i*8 +: 8] = pattern[i];
    end
  end

  // execute one beat
  always_comb begin
    pattern_next     = pattern;
    fill_pos_next    = fill_pos;
    too_long_next    = too_long;
    entry_count_next = entry_count;
    decided_next     = decided;
    emit             = 1'b0;
    emit_status      = fsns_pkg::ST_FOUND;
    emit_index       = '0;
    if (pop) begin
      if (!it.is_entry) begin
        // name byte
        if (it.first_char) begin
          for (int i = 0; i < fsns_pkg::NAME_LEN; i++) begin
            pattern_next[i] = fsns_pkg::CH_SPACE;
          end
          fill_pos_next    = '0;
          too_long_next    = 1'b0;
          entry_count_next = '0;
          decided_next     = 1'b0;
        end
        if (!it.name_zero) begin
          if (fill_pos_next >= fsns_pkg::FULL_POS) begin
            too_long_next = 1'b1;
          end else if (it.name_dot && fill_pos_next <= fsns_pkg::DOT_POS) begin
            fill_pos_next = fsns_pkg::DOT_POS;
          end else begin
            pattern_next[fill_pos_next] = it.name_byte;
            fill_pos_next = fill_pos_next + 1'b1;
          end
        end
      end else if (!decided) begin
        // directory entry
        emit = 1'b1;
        if (too_long) begin
          emit_status = fsns_pkg::ST_TOO_LONG;
        end else if (entry_count >= max_entries) begin
          emit_status = fsns_pkg::ST_NOT_FOUND;
        end else if (it.entry_end) begin
          emit_status = fsns_pkg::ST_NOT_FOUND;
        end else if (!it.entry_skip && it.entry_name == pattern_flat) begin
          emit_status = fsns_pkg::ST_FOUND;
          emit_index  = entry_count;
        end else begin
          entry_count_next = count_inc;
          emit_status      = fsns_pkg::ST_NOT_FOUND;
          emit             = (count_inc >= max_entries);
        end
        decided_next = emit;
      end
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsns_pkg::NAME_LEN; i++) begin
        pattern[i] <= fsns_pkg::CH_SPACE;
      end
      fill_pos    <= '0;
      too_long    <= 1'b0;
      entry_count <= '0;
      decided     <= 1'b0;
    end else begin
      pattern     <= pattern_next;
      fill_pos    <= fill_pos_next;
      too_long    <= too_long_next;
      entry_count <= entry_count_next;
      decided     <= decided_next;
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= fsns_pkg::MAX_ENTRIES_RST;
    end else if (cfg_wr_en) begin
      max_entries <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status <= emit_status;
      out_index  <= emit_index;
    end
  end

endmodule
`default_nettype wire
